// ----- src/imuctf_pkg.sv -----
// shared types, constants and tables of the imu tilt filter
`default_nettype none
package imuctf_pkg;

   localparam int NumChannelsDefault = 8;
   localparam int CordicStepsDefault = 16;

   localparam int CSR_AW = 4;

   localparam logic [1:0] REG_ALPHA       = 2'd0;
   localparam logic [1:0] REG_ALPHA_Z     = 2'd1;
   localparam logic [1:0] REG_GYRO_GAIN   = 2'd2;
   localparam logic [1:0] REG_FIRST_DT_MS = 2'd3;

   localparam logic [15:0] ALPHA_RESET       = 16'd64225;
   localparam logic [15:0] ALPHA_Z_RESET     = 16'd64225;
   localparam logic [31:0] GYRO_GAIN_RESET   = 32'd32786;
   localparam logic [15:0] FIRST_DT_MS_RESET = 16'd10;

   // 90 degrees in q16.16
   localparam logic signed [24:0] DEG90 = 25'sd5898240;
   localparam logic [40:0] STEP_LIMIT = 41'h100_0000_0000;
   localparam int SQRT_STEPS = 24;

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_SQ    = 12'b0000_0000_0010,
      S_LOAD  = 12'b0000_0000_0100,
      S_ROOT  = 12'b0000_0000_1000,
      S_CINIT = 12'b0000_0001_0000,
      S_ROT   = 12'b0000_0010_0000,
      S_GU    = 12'b0000_0100_0000,
      S_GP    = 12'b0000_1000_0000,
      S_GS    = 12'b0001_0000_0000,
      S_BM    = 12'b0010_0000_0000,
      S_BS    = 12'b0100_0000_0000,
      S_WB    = 12'b1000_0000_0000
   } state_type;

   // atan(2^-i) in q16.16 degrees
   function automatic logic [21:0] atan_entry(input logic [4:0] i);
      logic [21:0] v;
      case (i)
         5'd0:  v = 22'd2949120;
         5'd1:  v = 22'd1740967;
         5'd2:  v = 22'd919879;
         5'd3:  v = 22'd466945;
         5'd4:  v = 22'd234379;
         5'd5:  v = 22'd117304;
         5'd6:  v = 22'd58666;
         5'd7:  v = 22'd29335;
         5'd8:  v = 22'd14668;
         5'd9:  v = 22'd7334;
         5'd10: v = 22'd3667;
         5'd11: v = 22'd1833;
         5'd12: v = 22'd917;
         5'd13: v = 22'd458;
         5'd14: v = 22'd229;
         5'd15: v = 22'd115;
         5'd16: v = 22'd57;
         5'd17: v = 22'd29;
         5'd18: v = 22'd14;
         5'd19: v = 22'd7;
         5'd20: v = 22'd4;
         5'd21: v = 22'd2;
         5'd22: v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

   // negation that saturates the most negative value
   function automatic logic [31:0] neg_sat(input logic signed [31:0] v);
      logic [31:0] r;
      if (v == 32'sh8000_0000) begin
         r = 32'h7fff_ffff;
      end else begin
         r = 32'(-v);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- src/imuctf_ifs.sv -----
// request and response channel interfaces of the imu tilt filter
`default_nettype none
interface imuctf_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         chan;
   logic signed [15:0] acc_x;
   logic signed [15:0] acc_y;
   logic signed [15:0] acc_z;
   logic signed [15:0] rate_x;
   logic signed [15:0] rate_y;
   logic signed [15:0] rate_z;
   logic [31:0]        stamp_ms;
   modport source (output valid, chan, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z,
                   stamp_ms, input ready);
   modport sink (input valid, chan, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z,
                 stamp_ms, output ready);
endinterface

interface imuctf_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         out_chan;
   logic signed [23:0] pitch_acc;
   logic signed [23:0] roll_acc;
   logic signed [31:0] fused_x;
   logic signed [31:0] fused_y;
   logic signed [31:0] fused_z;
   modport source (output valid, out_chan, pitch_acc, roll_acc, fused_x, fused_y,
                   fused_z, input ready);
   modport sink (input valid, out_chan, pitch_acc, roll_acc, fused_x, fused_y,
                 fused_z, output ready);
endinterface
`default_nettype wire

// ----- src/imu_complementary_tilt_filter_core.sv -----
// imu complementary tilt filter: per-channel tilt fusion over a state memory
//
// One word is processed at a time. For each axis pair a 24-step bit-serial
// square root and a CORDIC of CORDIC_STEPS steps (fewer when y reaches zero)
// run in turn, pitch then roll, followed for each fused axis by the gyro
// step and blend states (GU, GP, GS, BM, BS), then one write back; the state
// memory is read when the word is accepted. A new word is accepted only once
// the previous one has been written back, and write back waits while the
// previous result is still held on the response channel. The per-channel
// state (angles and last stamp) lives in one synchronous memory of
// NUM_CHANNELS entries with valid bits, so reset needs no clearing pass. A
// word for a channel at or beyond NUM_CHANNELS is filtered from zero state
// and leaves the memory untouched.
`default_nettype none
module imu_complementary_tilt_filter_core #(
   parameter int NUM_CHANNELS = imuctf_pkg::NumChannelsDefault,
   parameter int CORDIC_STEPS = imuctf_pkg::CordicStepsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   imuctf_req_if.sink                    req,
   imuctf_rsp_if.source                  rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [imuctf_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import imuctf_pkg::*;

   localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CW = $clog2(CORDIC_STEPS + 1);
   localparam int ENTRY_W = 128;

   // configuration registers
   logic [15:0] alpha_ff, alpha_z_ff, first_dt_ff;
   logic [31:0] gain_ff;
   logic        csr_wr;
   logic [1:0]  csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = paddr[3:2];
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff    <= ALPHA_RESET;
         alpha_z_ff  <= ALPHA_Z_RESET;
         gain_ff     <= GYRO_GAIN_RESET;
         first_dt_ff <= FIRST_DT_MS_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_ALPHA:       alpha_ff    <= pwdata[15:0];
            REG_ALPHA_Z:     alpha_z_ff  <= pwdata[15:0];
            REG_GYRO_GAIN:   gain_ff     <= pwdata;
            REG_FIRST_DT_MS: first_dt_ff <= pwdata[15:0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_ALPHA:       prdata = {16'd0, alpha_ff};
         REG_ALPHA_Z:     prdata = {16'd0, alpha_z_ff};
         REG_GYRO_GAIN:   prdata = gain_ff;
         REG_FIRST_DT_MS: prdata = {16'd0, first_dt_ff};
         default:         prdata = 32'd0;
      endcase
   end

   // control
   state_type state_ff, state_in;
   logic      accept;
   logic      phase_ff;
   logic [1:0] axis_ff;
   logic [4:0] sq_cnt_ff;
   logic [CW-1:0] cnt_ff;
   logic      rot_done;
   logic      rsp_valid_ff;
   logic      rsp_load;

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign rsp_load  = (state_ff == S_WB) && (!rsp_valid_ff || rsp.ready);

   // captured word
   logic [2:0]         chan_ff;
   logic signed [15:0] ax_ff, ay_ff, az_ff, gx_ff, gy_ff, gz_ff;
   logic [31:0]        stamp_ff;
   logic               in_range_ff;

   // state memory and valid bits
   logic [ENTRY_W-1:0]    mem_ff [NUM_CHANNELS];
   logic [ENTRY_W-1:0]    rd_data_ff;
   logic [NUM_CHANNELS-1:0] valid_ff;
   logic                  rd_valid_ff;
   logic [IW+2:0]         req_chan_ext, chan_ext;
   logic                  req_in_range;
   logic                  wr_en;
   logic [ENTRY_W-1:0]    wr_data;

   assign req_chan_ext = (IW+3)'(req.chan);
   assign chan_ext     = (IW+3)'(chan_ff);
   assign req_in_range = (32'(req.chan) < NUM_CHANNELS);
   assign wr_en        = rsp_load && in_range_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= mem_ff[req_chan_ext[IW-1:0]];
      end
      if (wr_en) begin
         mem_ff[chan_ext[IW-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            rd_valid_ff <= req_in_range && valid_ff[req_chan_ext[IW-1:0]];
         end
         if (wr_en) begin
            valid_ff[chan_ext[IW-1:0]] <= 1'b1;
         end
      end
   end

   // previous state, zero when the entry was never written
   logic signed [31:0] prev_x, prev_y, prev_z;
   logic [31:0]        last_stamp, dt;

   assign prev_x     = rd_valid_ff ? rd_data_ff[127:96] : 32'sd0;
   assign prev_y     = rd_valid_ff ? rd_data_ff[95:64]  : 32'sd0;
   assign prev_z     = rd_valid_ff ? rd_data_ff[63:32]  : 32'sd0;
   assign last_stamp = rd_valid_ff ? rd_data_ff[31:0]   : 32'd0;
   assign dt = (last_stamp == 32'd0) ? {16'd0, first_dt_ff} : stamp_ff - last_stamp;

   // square root and cordic datapath
   logic [31:0]        sq_a_ff, sq_b_ff;
   logic [47:0]        rad_ff;
   logic [26:0]        rem_ff;
   logic [23:0]        root_ff;
   logic signed [26:0] cx_ff, cy_ff;
   logic signed [24:0] cz_ff;
   logic signed [23:0] pitch_ff, roll_ff;

   logic signed [15:0] sel_a;
   logic signed [16:0] sel_num;
   logic [26:0]        rem_t, trial;
   logic               root_ge;
   logic signed [26:0] dx, dy;
   logic signed [24:0] atan_v, z_clamped;

   assign sel_a   = phase_ff ? ay_ff : ax_ff;
   assign sel_num = phase_ff ? -17'(ax_ff) : 17'(ay_ff);
   assign rem_t   = {rem_ff[24:0], rad_ff[47:46]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign root_ge = (rem_t >= trial);
   assign dx      = cx_ff >>> cnt_ff;
   assign dy      = cy_ff >>> cnt_ff;
   assign atan_v  = signed'({3'b000, atan_entry(5'(cnt_ff))});
   assign rot_done = (cy_ff == 27'sd0) || (cnt_ff == CW'(CORDIC_STEPS));

   always_comb begin
      if (cz_ff > DEG90) begin
         z_clamped = DEG90;
      end else if (cz_ff < -DEG90) begin
         z_clamped = -DEG90;
      end else begin
         z_clamped = cz_ff;
      end
   end

   // gyro step and blend datapath
   logic [47:0]        u_ff;
   logic [63:0]        phi_ff, plo_ff;
   logic signed [42:0] g_ff;
   logic signed [59:0] pw_ff;
   logic signed [41:0] pa_ff;
   logic signed [31:0] nx_ff, ny_ff, nz_ff;

   logic signed [15:0] rate_sel;
   logic               neg_sel;
   logic signed [31:0] prev_sel;
   logic signed [23:0] acc_sel;
   logic [15:0]        w_sel;
   logic [16:0]        w_comp;
   logic [15:0]        mag;
   logic [63:0]        t_sum;
   logic [40:0]        t_sat;
   logic signed [41:0] step_s;
   logic signed [60:0] total;
   logic signed [44:0] shifted;
   logic signed [31:0] blend_res;

   always_comb begin
      case (axis_ff)
         2'd0: begin
            rate_sel = gy_ff;
            neg_sel  = 1'b0;
            prev_sel = prev_x;
            acc_sel  = pitch_ff;
            w_sel    = alpha_ff;
         end
         2'd1: begin
            rate_sel = gx_ff;
            neg_sel  = 1'b1;
            prev_sel = prev_y;
            acc_sel  = roll_ff;
            w_sel    = alpha_ff;
         end
         default: begin
            rate_sel = gz_ff;
            neg_sel  = 1'b0;
            prev_sel = prev_z;
            acc_sel  = 24'sd0;
            w_sel    = alpha_z_ff;
         end
      endcase
   end

   assign w_comp = 17'h10000 - {1'b0, w_sel};
   assign mag    = rate_sel[15] ? 16'(-rate_sel) : 16'(rate_sel);
   assign t_sum  = phi_ff + (plo_ff >> 16);
   assign t_sat  = (t_sum > 64'(STEP_LIMIT)) ? STEP_LIMIT : t_sum[40:0];
   assign step_s = (rate_sel[15] != neg_sel) ? -signed'({1'b0, t_sat})
                                             : signed'({1'b0, t_sat});
   assign total  = 61'(pw_ff) + 61'(pa_ff) + 61'sd32768;
   assign shifted = 45'(total >>> 16);

   always_comb begin
      if (shifted > 45'sd2147483647) begin
         blend_res = 32'sh7fff_ffff;
      end else if (shifted < -45'sd2147483648) begin
         blend_res = 32'sh8000_0000;
      end else begin
         blend_res = shifted[31:0];
      end
   end

   assign wr_data = {nx_ff, ny_ff, nz_ff, stamp_ff};

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_SQ;
         S_SQ:    state_in = S_LOAD;
         S_LOAD:  state_in = S_ROOT;
         S_ROOT:  if (sq_cnt_ff == 5'(SQRT_STEPS - 1)) state_in = S_CINIT;
         S_CINIT: state_in = S_ROT;
         S_ROT: begin
            if (rot_done) begin
               state_in = phase_ff ? S_GU : S_SQ;
            end
         end
         S_GU:    state_in = S_GP;
         S_GP:    state_in = S_GS;
         S_GS:    state_in = S_BM;
         S_BM:    state_in = S_BS;
         S_BS:    state_in = (axis_ff == 2'd2) ? S_WB : S_GU;
         S_WB:    if (rsp_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               chan_ff     <= req.chan;
               ax_ff       <= req.acc_x;
               ay_ff       <= req.acc_y;
               az_ff       <= req.acc_z;
               gx_ff       <= req.rate_x;
               gy_ff       <= req.rate_y;
               gz_ff       <= req.rate_z;
               stamp_ff    <= req.stamp_ms;
               in_range_ff <= req_in_range;
               phase_ff    <= 1'b0;
               axis_ff     <= 2'd0;
            end
         end
         S_SQ: begin
            sq_a_ff <= 32'(sel_a * sel_a);
            sq_b_ff <= 32'(az_ff * az_ff);
         end
         S_LOAD: begin
            rad_ff    <= {sq_a_ff + sq_b_ff, 16'd0};
            rem_ff    <= '0;
            root_ff   <= '0;
            sq_cnt_ff <= '0;
         end
         S_ROOT: begin
            rem_ff    <= root_ge ? rem_t - trial : rem_t;
            root_ff   <= {root_ff[22:0], root_ge};
            rad_ff    <= rad_ff << 2;
            sq_cnt_ff <= sq_cnt_ff + 5'd1;
         end
         S_CINIT: begin
            cx_ff  <= signed'({3'b000, root_ff});
            cy_ff  <= {{2{sel_num[16]}}, sel_num, 8'd0};
            cz_ff  <= '0;
            cnt_ff <= '0;
         end
         S_ROT: begin
            if (!rot_done) begin
               if (!cy_ff[26]) begin
                  cx_ff <= cx_ff + dy;
                  cy_ff <= cy_ff - dx;
                  cz_ff <= cz_ff + atan_v;
               end else begin
                  cx_ff <= cx_ff - dy;
                  cy_ff <= cy_ff + dx;
                  cz_ff <= cz_ff - atan_v;
               end
               cnt_ff <= cnt_ff + CW'(1);
            end else begin
               if (phase_ff) begin
                  roll_ff <= z_clamped[23:0];
               end else begin
                  pitch_ff <= z_clamped[23:0];
               end
               phase_ff <= 1'b1;
            end
         end
         S_GU: u_ff <= 48'(mag * dt);
         S_GP: begin
            phi_ff <= 64'(u_ff * gain_ff[31:16]);
            plo_ff <= 64'(u_ff * gain_ff[15:0]);
         end
         S_GS: g_ff <= 43'(prev_sel) + 43'(step_s);
         S_BM: begin
            pw_ff <= 60'(signed'({1'b0, w_sel}) * g_ff);
            pa_ff <= 42'(signed'({1'b0, w_comp}) * acc_sel);
         end
         S_BS: begin
            case (axis_ff)
               2'd0:    nx_ff <= blend_res;
               2'd1:    ny_ff <= blend_res;
               default: nz_ff <= blend_res;
            endcase
            axis_ff <= axis_ff + 2'd1;
         end
         default: ;
      endcase
   end

   // output register
   logic [2:0]         out_chan_ff;
   logic signed [23:0] pitch_out_ff, roll_out_ff;
   logic [31:0]        fx_ff, fy_ff, fz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         out_chan_ff  <= chan_ff;
         pitch_out_ff <= pitch_ff;
         roll_out_ff  <= roll_ff;
         fx_ff        <= neg_sat(nx_ff);
         fy_ff        <= neg_sat(ny_ff);
         fz_ff        <= neg_sat(nz_ff);
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_chan  = out_chan_ff;
   assign rsp.pitch_acc = pitch_out_ff;
   assign rsp.roll_acc  = roll_out_ff;
   assign rsp.fused_x   = fx_ff;
   assign rsp.fused_y   = fy_ff;
   assign rsp.fused_z   = fz_ff;

   // checks
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req.ready)
      else $error("word accepted while another is in flight");

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (32'(chan_ff) < NUM_CHANNELS))
      else $error("state write for channel out of range");

   a_rsp_from_wb: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_WB))
      else $error("response raised outside write back");

   a_cordic_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROT) |-> (cnt_ff <= CW'(CORDIC_STEPS)))
      else $error("cordic step count overran");

endmodule
`default_nettype wire
